// ===== rtl/gpio_change_monitor_pulse_out_core_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef GPIO_CHANGE_MONITOR_PULSE_OUT_CORE_MACROS_SVH
`define GPIO_CHANGE_MONITOR_PULSE_OUT_CORE_MACROS_SVH

// Same-cycle implication.
`define GCM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcm assertion failed");

// Next-cycle implication.
`define GCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcm assertion failed");

`endif

// ===== rtl/gcm_pkg.sv =====
package gcm_pkg;

   localparam int MAX_GROUPS = 5;
   localparam int BYTE_W     = 8;
   localparam int LEVEL_W    = 40;
   localparam int GRP_W      = 3;
   localparam int BIT_W      = 4;
   localparam int BSEL_W     = 3;
   localparam int STAT_W     = 2;
   localparam int TICK_W     = 8;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 8;

   localparam logic [MAX_GROUPS-1:0] RESET_OUT_MASK    = '0;
   localparam logic [TICK_W-1:0]     RESET_PULSE_TICKS = 8'd50;
   localparam logic [TICK_W-1:0]     RESET_LED_TICKS   = 8'd40;

   typedef enum logic [1:0] {
      CSR_OUT_MASK    = 2'd0,
      CSR_PULSE_TICKS = 2'd1,
      CSR_LED_TICKS   = 2'd2
   } csr_idx_type;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_PULSE = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_CHANGE = 1'b0,
      KIND_DONE   = 1'b1
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_INDEX  = 2'd1,
      STAT_NOT_OUTPUT = 2'd2
   } status_type;

   // per-lane control for one accepted word
   typedef struct packed {
      logic              tick;
      logic              clr;
      logic [BSEL_W-1:0] clr_bit;
   } lane_ctl_type;

   typedef struct packed {
      logic restart;
      logic step;
   } timer_ctl_type;

   // what the merge stage keeps of one accepted word
   typedef struct packed {
      logic [LEVEL_W-1:0] levels;
      status_type         status;
      logic [LEVEL_W-1:0] drive;
      logic               led;
   } rec_type;

endpackage

// ===== rtl/gcm_req_if.sv =====
interface gcm_req_if import gcm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [GRP_W-1:0]   group_index;
   logic [BIT_W-1:0]   bit_index;
   logic [LEVEL_W-1:0] input_levels;

   modport source (output valid, command, group_index, bit_index, input_levels,
                   input ready);
   modport sink (input valid, command, group_index, bit_index, input_levels,
                 output ready);
   modport monitor (input valid, ready, command, group_index, bit_index,
                    input_levels);
endinterface

// ===== rtl/gcm_rsp_if.sv =====
interface gcm_rsp_if import gcm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [GRP_W-1:0]   report_group;
   logic [BYTE_W-1:0]  report_value;
   logic [STAT_W-1:0]  status;
   logic [LEVEL_W-1:0] output_drive;
   logic               led_on;
   logic               last;

   modport source (output valid, kind, report_group, report_value, status,
                   output_drive, led_on, last, input ready);
   modport sink (input valid, kind, report_group, report_value, status,
                 output_drive, led_on, last, output ready);
   modport monitor (input valid, ready, kind, report_group, report_value, status,
                    output_drive, led_on, last);
endinterface

// ===== rtl/gcm_lane.sv =====
// One I/O group: stored image and change detect.
module gcm_lane import gcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              is_input,
   input  lane_ctl_type      ctl,
   input  logic [BYTE_W-1:0] level,
   output logic              change
);

   logic [BYTE_W-1:0] image_ff;
   logic [BYTE_W-1:0] image_in;

   always_comb begin
      change   = ctl.tick & is_input & (level != image_ff);
      image_in = image_ff;
      if (change) begin
         image_in = level;
      end
      if (ctl.clr) begin
         image_in = image_ff & ~(BYTE_W'(1) << ctl.clr_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff <= '1;
      end else if (en) begin
         image_ff <= image_in;
      end
   end

endmodule

// ===== rtl/gcm_timer.sv =====
// Tick timer: restart, saturating count, expire at limit.
module gcm_timer import gcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  timer_ctl_type     ctl,
   input  logic [TICK_W-1:0] limit,
   output logic              expire,
   output logic              active_nxt
);

   logic              active_ff, active_in, active_mid;
   logic [TICK_W-1:0] cnt_ff, cnt_in, cnt_mid, cnt_inc;

   always_comb begin
      active_mid = ctl.restart | active_ff;
      cnt_mid    = ctl.restart ? '0 : cnt_ff;
      cnt_inc    = (cnt_mid == '1) ? cnt_mid : cnt_mid + TICK_W'(1);
      expire     = ctl.step & active_mid & (cnt_inc >= limit);
      active_in  = active_mid;
      cnt_in     = cnt_mid;
      if (ctl.step && active_mid) begin
         active_in = ~expire;
         cnt_in    = expire ? '0 : cnt_inc;
      end
      active_nxt = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (en) begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== rtl/gcm_merge.sv =====
// Merge stage: holds one word's lane results and sends change reports
// lowest group first, then the completion word.
module gcm_merge import gcm_pkg::*; #(
   parameter int GROUPS = MAX_GROUPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [GROUPS-1:0] change,
   input  rec_type           rec,
   output logic              ready,
   gcm_rsp_if.source         rsp
);

   logic              valid_ff, valid_in;
   logic [GROUPS-1:0] pend_ff, pend_in, low;
   rec_type           rec_ff, rec_in;
   logic [GRP_W-1:0]  sel;
   logic              done, fire;

   always_comb begin
      low = pend_ff & (~pend_ff + GROUPS'(1));
      sel = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (low[g]) begin
            sel = sel | GRP_W'(g);
         end
      end
      done  = (pend_ff == '0);
      fire  = valid_ff & rsp.ready;
      ready = ~valid_ff | (rsp.ready & done);

      valid_in = valid_ff;
      pend_in  = pend_ff;
      rec_in   = rec_ff;
      if (fire) begin
         if (done) begin
            valid_in = 1'b0;
         end else begin
            pend_in = pend_ff & ~low;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         pend_in  = change;
         rec_in   = rec;
      end
   end

   always_comb begin
      rsp.valid        = valid_ff;
      rsp.kind         = done ? KIND_DONE : KIND_CHANGE;
      rsp.report_group = done ? '0 : sel;
      rsp.report_value = done ? '0 : rec_ff.levels[{sel, 3'b000} +: BYTE_W];
      rsp.status       = done ? rec_ff.status : STAT_OK;
      rsp.output_drive = rec_ff.drive;
      rsp.led_on       = rec_ff.led;
      rsp.last         = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ===== rtl/gpio_change_monitor_pulse_out_core.sv =====
// channel  dir  handshake          payload
// req_ch   in   valid/ready        command, group_index, bit_index, input_levels
// rsp_ch   out  valid/ready        kind, report_group, report_value, status,
//                                  output_drive, led_on, last
// csr      in   APB (psel/penable) output_group_mask @0, pulse_ticks @4,
//                                  led_ticks @8
//
// A word yields one report per changed input group, then a completion word,
// sent from the merge stage one result word per cycle unless rsp_ch stalls.
// The lanes and timers update state in the cycle a word is accepted; the
// next word is taken in the same cycle the last result of this one leaves.
// Reset is synchronous; images and drive come up all ones, timers idle.
// A stall on rsp_ch holds the merge stage and with it req_ch.ready.
module gpio_change_monitor_pulse_out_core import gcm_pkg::*; #(
   parameter int GROUPS = MAX_GROUPS
) (
   input  logic              clock,
   input  logic              reset,
   gcm_req_if.sink           req_ch,
   gcm_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   // ---- configuration registers ----
   logic [MAX_GROUPS-1:0] out_mask_ff;
   logic [TICK_W-1:0]     pulse_ticks_ff;
   logic [TICK_W-1:0]     led_ticks_ff;
   logic                  csr_wr;
   csr_idx_type           csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_sel = csr_idx_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_mask_ff    <= RESET_OUT_MASK;
         pulse_ticks_ff <= RESET_PULSE_TICKS;
         led_ticks_ff   <= RESET_LED_TICKS;
      end else if (csr_wr) begin
         case (csr_sel)
            CSR_OUT_MASK:    out_mask_ff    <= pwdata[MAX_GROUPS-1:0];
            CSR_PULSE_TICKS: pulse_ticks_ff <= pwdata[TICK_W-1:0];
            CSR_LED_TICKS:   led_ticks_ff   <= pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_OUT_MASK:    prdata = DATA_W'(out_mask_ff);
         CSR_PULSE_TICKS: prdata = DATA_W'(pulse_ticks_ff);
         CSR_LED_TICKS:   prdata = DATA_W'(led_ticks_ff);
         default:         prdata = '0;
      endcase
   end

   // ---- command decode ----
   logic                 accept;
   logic                 is_tick;
   logic                 grp_ok, bit_ok, tgt_out, pulse_ok;
   logic [IDX_W-1:0]     mask_ext;
   status_type           status;
   logic                 ready;

   assign accept   = req_ch.valid & ready;
   assign req_ch.ready = ready;
   assign is_tick  = (req_ch.command == CMD_TICK);
   assign grp_ok   = req_ch.group_index < GRP_W'(GROUPS);
   assign bit_ok   = req_ch.bit_index < BIT_W'(BYTE_W);
   assign mask_ext = IDX_W'(out_mask_ff);
   assign tgt_out  = mask_ext[req_ch.group_index];
   assign pulse_ok = ~is_tick & grp_ok & bit_ok & tgt_out;

   always_comb begin
      if (is_tick) begin
         status = STAT_OK;
      end else if (!(grp_ok && bit_ok)) begin
         status = STAT_BAD_INDEX;
      end else if (!tgt_out) begin
         status = STAT_NOT_OUTPUT;
      end else begin
         status = STAT_OK;
      end
   end

   // ---- group lanes ----
   logic [GROUPS-1:0] change;
   logic              any_change;

   for (genvar g = 0; g < GROUPS; g++) begin : g_lane
      lane_ctl_type lctl;
      always_comb begin
         lctl.tick    = is_tick;
         lctl.clr     = pulse_ok & (req_ch.group_index == GRP_W'(g));
         lctl.clr_bit = req_ch.bit_index[BSEL_W-1:0];
      end
      gcm_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (accept),
         .is_input (~out_mask_ff[g]),
         .ctl      (lctl),
         .level    (req_ch.input_levels[BYTE_W*g +: BYTE_W]),
         .change   (change[g])
      );
   end

   assign any_change = |change;

   // ---- timers: pulse release and activity LED ----
   timer_ctl_type pulse_ctl, led_ctl;
   logic          pulse_expire, pulse_active_nxt;
   logic          led_expire, led_active_nxt;

   assign pulse_ctl = '{restart: pulse_ok, step: is_tick};
   assign led_ctl   = '{restart: pulse_ok | any_change, step: is_tick};

   gcm_timer u_pulse_timer (
      .clock      (clock),
      .reset      (reset),
      .en         (accept),
      .ctl        (pulse_ctl),
      .limit      (pulse_ticks_ff),
      .expire     (pulse_expire),
      .active_nxt (pulse_active_nxt)
   );

   gcm_timer u_led_timer (
      .clock      (clock),
      .reset      (reset),
      .en         (accept),
      .ctl        (led_ctl),
      .limit      (led_ticks_ff),
      .expire     (led_expire),
      .active_nxt (led_active_nxt)
   );

   // ---- output drive ----
   logic [LEVEL_W-1:0] drive_ff, drive_in;

   always_comb begin
      drive_in = drive_ff;
      if (pulse_ok) begin
         // drive the addressed bit low
         drive_in = drive_ff &
                    ~(LEVEL_W'(1) << {req_ch.group_index, req_ch.bit_index[BSEL_W-1:0]});
      end
      if (pulse_expire) begin
         // release: every group that is an output now goes back to all ones
         for (int g = 0; g < GROUPS; g++) begin
            if (out_mask_ff[g]) begin
               drive_in[BYTE_W*g +: BYTE_W] = '1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '1;
      end else if (accept) begin
         drive_ff <= drive_in;
      end
   end

   // ---- merge stage ----
   rec_type rec;

   always_comb begin
      rec.levels = req_ch.input_levels;
      rec.status = status;
      rec.drive  = drive_in;
      rec.led    = led_active_nxt & (led_expire | 1'b1);
   end

   gcm_merge #(.GROUPS(GROUPS)) u_merge (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .change (change),
      .rec    (rec),
      .ready  (ready),
      .rsp    (rsp_ch)
   );

endmodule

// ===== rtl/gcm_checker.sv =====
`include "gpio_change_monitor_pulse_out_core_macros.svh"

module gcm_checker import gcm_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_kind,
   input logic [GRP_W-1:0] rsp_group,
   input logic [STAT_W-1:0] rsp_status,
   input logic             rsp_last
);

   logic rsp_fire;
   logic rsp_chg;
   logic rsp_done;
   logic chg_ok;
   logic chg_fire;

   assign rsp_fire = rsp_valid & rsp_ready;
   assign rsp_done = (rsp_kind == KIND_DONE);
   assign rsp_chg  = rsp_valid & (rsp_kind == KIND_CHANGE);
   assign chg_ok   = (rsp_status == STAT_OK) && (rsp_group < GRP_W'(MAX_GROUPS));
   assign chg_fire = rsp_fire & rsp_chg;

   // last marks the completion word and nothing else
   `GCM_ASSERT_IMPLY(a_last_is_done, clock, reset, rsp_valid, rsp_last == rsp_done)
   // change reports carry ok status and a real group
   `GCM_ASSERT_IMPLY(a_chg_fields, clock, reset, rsp_chg, chg_ok)
   // a word's results stay contiguous up to its completion
   `GCM_ASSERT_NEXT(a_no_gap, clock, reset, rsp_fire && !rsp_last, rsp_valid)
   // reports of one word come in rising group order
   `GCM_ASSERT_IMPLY(a_grp_order, clock, reset, chg_fire ##1 chg_fire, rsp_group > $past(rsp_group))
   // the next word is taken as the completion leaves
   `GCM_ASSERT_IMPLY(a_ready_at_done, clock, reset, rsp_fire && rsp_last, req_ready)

endmodule

bind gpio_change_monitor_pulse_out_core gcm_checker u_gcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.kind),
   .rsp_group  (rsp_ch.report_group),
   .rsp_status (rsp_ch.status),
   .rsp_last   (rsp_ch.last)
);

// ===== bench/gpio_change_monitor_pulse_out_core_test.sv =====
`timescale 1ns / 100ps

// Bench for the GPIO change monitor with timed output pulse.
// A request word is either a tick (sampled levels of all groups) or a pulse
// request (one bit of one group driven low). Each word yields a change
// report for each changed input group in group order, then a completion word. A
// behavioral copy of the block runs alongside: every accepted request word
// queues the words it expects, and the result monitor checks each result
// word field by field against the head of that queue.
module gpio_change_monitor_pulse_out_core_test;
   import gcm_pkg::*;

   localparam int LIMIT       = 300000;  // cycle ceiling for the whole run
   localparam int N_DIR       = 33;      // rows in the directed table
   localparam int PHASES      = 5;       // random phases, each with new settings
   localparam int PHASE_WORDS = 50;      // request words per random phase
   localparam int HOLD_AT     = 120;     // words taken before the long hold-off
   localparam int HOLD_LEN    = 300;     // length of the hold-off in cycles
   localparam int DRAIN       = 20;      // quiet cycles after the last result

   localparam logic [LEVEL_W-1:0] ALL_ONES = '1;

   // one expected result word
   typedef struct packed {
      kind_type           kind;
      logic [GRP_W-1:0]   grp;
      logic [BYTE_W-1:0]  value;
      status_type         status;
      logic [LEVEL_W-1:0] drive;
      logic               led;
      logic               last;
   } rsp_word_t;

   // directed table: either a request word or a register write
   typedef enum logic {
      ACT_WORD = 1'b0,
      ACT_CSR  = 1'b1
   } row_act_t;

   typedef struct packed {
      row_act_t           act;
      cmd_type            cmd;
      logic [GRP_W-1:0]   grp;
      logic [BIT_W-1:0]   bsel;
      logic [LEVEL_W-1:0] data;   // levels of a word, or the register value
      logic               pin;    // completion status typed in below
      status_type         want;
      csr_idx_type        csr;
   } dir_row_t;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_OPEN  = 2'd0,
      RX_LIGHT = 2'd1,
      RX_HEAVY = 2'd2,
      RX_BEAT  = 2'd3
   } rx_mode_t;

   logic                clock   = 1'b0;
   logic                reset   = 1'b1;
   logic                psel    = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite  = 1'b0;
   logic [ADDR_W-1:0]   paddr   = '0;
   logic [DATA_W-1:0]   pwdata  = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   gcm_req_if req_ch ();
   gcm_rsp_if rsp_ch ();

   gpio_change_monitor_pulse_out_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: registers and state as they stand after the
   // last accepted request word.
   // ---------------------------------------------------------------------
   logic [MAX_GROUPS-1:0] out_mask  = RESET_OUT_MASK;
   logic [TICK_W-1:0]     pulse_len = RESET_PULSE_TICKS;
   logic [TICK_W-1:0]     led_len   = RESET_LED_TICKS;
   logic [BYTE_W-1:0]     image [MAX_GROUPS];
   logic [LEVEL_W-1:0]    drive_now = '1;
   logic                  pulse_low = 1'b0;
   logic [TICK_W-1:0]     pulse_age = '0;
   logic                  led_lit   = 1'b0;
   logic [TICK_W-1:0]     led_age   = '0;

   rsp_word_t due [$];          // result words still owed by the block

   int errors     = 0;
   int rsp_seen   = 0;
   int cycles     = 0;
   int burst_left = 0;

   initial begin
      foreach (image[g])
         image[g] = '1;
   end

   task automatic report_error(input string msg);
      errors++;
      if (errors <= 200)
         $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string what, input logic [LEVEL_W-1:0] got,
                              input logic [LEVEL_W-1:0] want);
      if (got !== want)
         report_error($sformatf("result word %0d %s: got %h, want %h",
                                rsp_seen, what, got, want));
   endtask

   // Applies one request word to the shadow state and queues the words it
   // causes. Tick order: change scan, then pulse timer, then LED timer.
   task automatic gpio_step(input cmd_type cmd, input logic [GRP_W-1:0] grp,
                            input logic [BIT_W-1:0] bsel,
                            input logic [LEVEL_W-1:0] lv,
                            input logic pin, input status_type want);
      rsp_word_t         words [$];
      rsp_word_t         w;
      logic [BYTE_W-1:0] b;
      status_type        st;
      int                g;
      st = STAT_OK;
      if (cmd == CMD_TICK) begin
         for (g = 0; g < MAX_GROUPS; g++) begin
            b = lv[BYTE_W*g +: BYTE_W];
            if (!out_mask[g] && b != image[g]) begin
               w = '0;
               w.kind  = KIND_CHANGE;
               w.grp   = GRP_W'(g);
               w.value = b;
               words.push_back(w);
               image[g] = b;
               led_lit  = 1'b1;
               led_age  = '0;
            end
         end
         if (pulse_low) begin
            if (pulse_age != '1)
               pulse_age++;
            // release only what is an output now
            if (pulse_age >= pulse_len) begin
               for (g = 0; g < MAX_GROUPS; g++)
                  if (out_mask[g])
                     drive_now[BYTE_W*g +: BYTE_W] = '1;
               pulse_low = 1'b0;
               pulse_age = '0;
            end
         end
         if (led_lit) begin
            if (led_age != '1)
               led_age++;
            if (led_age >= led_len) begin
               led_lit = 1'b0;
               led_age = '0;
            end
         end
      end else if (grp >= MAX_GROUPS || bsel >= BYTE_W) begin
         st = STAT_BAD_INDEX;
      end else if (!out_mask[grp]) begin
         st = STAT_NOT_OUTPUT;
      end else begin
         drive_now[BYTE_W*grp + bsel] = 1'b0;
         image[grp][bsel] = 1'b0;
         pulse_low = 1'b1;
         pulse_age = '0;
         led_lit   = 1'b1;
         led_age   = '0;
      end
      w = '0;
      w.kind   = KIND_DONE;
      w.status = pin ? want : st;
      w.last   = 1'b1;
      words.push_back(w);
      // drive and LED are the values after the whole word
      foreach (words[i]) begin
         words[i].drive = drive_now;
         words[i].led   = led_lit;
         due.push_back(words[i]);
      end
   endtask

   // Offers one request word; the sender runs in bursts with gaps between.
   // A gap always holds valid low across a clock edge, so valid never falls and rises in one step.
   task automatic send_word(input cmd_type cmd, input logic [GRP_W-1:0] grp,
                            input logic [BIT_W-1:0] bsel,
                            input logic [LEVEL_W-1:0] lv,
                            input logic pin, input status_type want);
      int gap;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                           : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.group_index  <= grp;
      req_ch.bit_index    <= bsel;
      req_ch.input_levels <= lv;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      burst_left--;
      gpio_step(cmd, grp, bsel, lv, pin, want);
   endtask

   // Stops offering and waits until every owed result word has left.
   // Every word yields a completion, so an empty queue means idle.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do
         @(posedge clock);
      while (due.size() != 0);
   endtask

   // APB write, then a read back of the same register. psel stays high
   // from the write's last edge into the read's setup.
   task automatic set_csr(input csr_idx_type idx, input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] held;
      case (idx)
         CSR_OUT_MASK: begin
            out_mask = data[MAX_GROUPS-1:0];
            held     = DATA_W'(out_mask);
         end
         CSR_PULSE_TICKS: begin
            pulse_len = data[TICK_W-1:0];
            held      = DATA_W'(pulse_len);
         end
         default: begin
            led_len = data[TICK_W-1:0];
            held    = DATA_W'(led_len);
         end
      endcase
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== held)
         report_error($sformatf("register %s read %h, want %h", idx.name(), prdata, held));
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Directed table. Completion status is typed in where it is plain:
   // right after reset, bad indexes, pulses to inputs, simple good pulses.
   // ---------------------------------------------------------------------
   localparam dir_row_t DIR_ROWS [N_DIR] = '{
      // reset state: all ones in, nothing changes
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      // every group drops to zero
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0000, 1'b0, STAT_OK,         CSR_OUT_MASK},
      // pulse to an input group
      '{ACT_WORD, CMD_PULSE, 3'd0, 4'd0,  40'h00_0000_0000, 1'b1, STAT_NOT_OUTPUT, CSR_OUT_MASK},
      // bad group, bad group and bit, bad bit
      '{ACT_WORD, CMD_PULSE, 3'd5, 4'd0,  ALL_ONES,         1'b1, STAT_BAD_INDEX,  CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd7, 4'd15, ALL_ONES,         1'b1, STAT_BAD_INDEX,  CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd4, 4'd8,  ALL_ONES,         1'b1, STAT_BAD_INDEX,  CSR_OUT_MASK},
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  40'hA5_5AC3_3C81, 1'b0, STAT_OK,         CSR_OUT_MASK},
      // groups 0, 2, 4 become outputs; upper write bits are junk
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_FFFF_FFF5, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0001, 1'b0, STAT_OK,         CSR_PULSE_TICKS},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_00FF, 1'b0, STAT_OK,         CSR_LED_TICKS},
      '{ACT_WORD, CMD_PULSE, 3'd0, 4'd7,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd4, 4'd0,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      // one-tick pulse expires here
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  ALL_ONES,         1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd2, 4'd3,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      // group 2 turns input while its bit is low: release leaves it low
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0001, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0000, 1'b0, STAT_OK,         CSR_OUT_MASK},
      // zero timers expire on the first tick
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0000, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0000, 1'b0, STAT_OK,         CSR_PULSE_TICKS},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0000, 1'b0, STAT_OK,         CSR_LED_TICKS},
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  40'h01_0204_0810, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_001F, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd3, 4'd5,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      // all outputs: no reports
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  40'h55_AA55_AA55, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd1, 4'd7,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd1, 4'd6,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  ALL_ONES,         1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_00FF, 1'b0, STAT_OK,         CSR_PULSE_TICKS},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0001, 1'b0, STAT_OK,         CSR_LED_TICKS},
      '{ACT_CSR,  CMD_TICK,  3'd0, 4'd0,  40'h00_0000_000A, 1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd3, 4'd2,  ALL_ONES,         1'b1, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_PULSE, 3'd0, 4'd2,  ALL_ONES,         1'b1, STAT_NOT_OUTPUT, CSR_OUT_MASK},
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  ALL_ONES,         1'b0, STAT_OK,         CSR_OUT_MASK},
      '{ACT_WORD, CMD_TICK,  3'd0, 4'd0,  40'h00_0000_0000, 1'b0, STAT_OK,         CSR_OUT_MASK}
   };

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [LEVEL_W-1:0] lv;
      int                 i;
      int                 p;
      int                 k;
      int                 g;
      int                 pick;
      req_ch.valid        <= 1'b0;
      req_ch.command      <= CMD_TICK;
      req_ch.group_index  <= '0;
      req_ch.bit_index    <= '0;
      req_ch.input_levels <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part; the first rows run on reset register values
      for (i = 0; i < N_DIR; i++) begin
         if (DIR_ROWS[i].act == ACT_CSR) begin
            drain_block();
            set_csr(DIR_ROWS[i].csr, DIR_ROWS[i].data[DATA_W-1:0]);
         end else begin
            send_word(DIR_ROWS[i].cmd, DIR_ROWS[i].grp, DIR_ROWS[i].bsel,
                      DIR_ROWS[i].data, DIR_ROWS[i].pin, DIR_ROWS[i].want);
         end
      end

      // random phases: fresh settings each, extremes of the mask first
      for (p = 0; p < PHASES; p++) begin
         drain_block();
         set_csr(CSR_OUT_MASK, (p == 0) ? 32'h0 : (p == 1) ? 32'h1F : $urandom);
         pick = $urandom_range(0, 5);
         set_csr(CSR_PULSE_TICKS, (pick == 0) ? 32'd255 : (pick == 1) ? 32'd0
                                                        : $urandom_range(1, 6));
         pick = $urandom_range(0, 5);
         set_csr(CSR_LED_TICKS, (pick == 0) ? 32'd255 : (pick == 1) ? 32'd0
                                                      : $urandom_range(1, 8));
         for (k = 0; k < PHASE_WORDS; k++) begin
            lv = {$urandom, $urandom};
            if ($urandom_range(0, 9) < 7) begin
               // mostly ticks where a few groups move and the rest hold
               if ($urandom_range(0, 5) != 0)
                  for (g = 0; g < MAX_GROUPS; g++)
                     if ($urandom_range(0, 2) != 0)
                        lv[BYTE_W*g +: BYTE_W] = image[g];
               send_word(CMD_TICK, GRP_W'($urandom), BIT_W'($urandom), lv,
                         1'b0, STAT_OK);
            end else if ($urandom_range(0, 6) != 0) begin
               send_word(CMD_PULSE, GRP_W'($urandom_range(0, MAX_GROUPS-1)),
                         BIT_W'($urandom_range(0, BYTE_W-1)), lv, 1'b0, STAT_OK);
            end else begin
               // any index, bad ones included
               send_word(CMD_PULSE, GRP_W'($urandom), BIT_W'($urandom), lv,
                         1'b0, STAT_OK);
            end
         end
      end

      drain_block();
      repeat (DRAIN) @(posedge clock);
      if (due.size() != 0)
         report_error($sformatf("%0d result words never arrived", due.size()));
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern that changes after each span of random length, with
   // open stretches, plus one long hold-off once traffic is under way so
   // the block backs up into its request port.
   // ---------------------------------------------------------------------
   rx_mode_t rx_mode   = RX_OPEN;
   int       rx_span   = 0;
   int       rx_phase  = 0;
   int       hold_left = 0;
   logic     hold_done = 1'b0;
   int       req_taken = 0;

   always @(posedge clock) begin
      rx_phase <= rx_phase + 1;
      if (!reset && req_ch.valid && req_ch.ready)
         req_taken <= req_taken + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && req_taken >= HOLD_AT) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_LEN;
         hold_done    <= 1'b1;
      end else begin
         if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 120);
         end else begin
            rx_span <= rx_span - 1;
         end
         case (rx_mode)
            RX_OPEN:  rsp_ch.ready <= 1'b1;
            RX_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:  rsp_ch.ready <= (rx_phase % 7) < 4;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: every accepted result word against the oldest one owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_t w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (due.size() == 0) begin
            report_error($sformatf("result word %0d arrived with nothing owed", rsp_seen));
         end else begin
            w = due.pop_front();
            check_field("kind",         rsp_ch.kind,         w.kind);
            check_field("report_group", rsp_ch.report_group, w.grp);
            check_field("report_value", rsp_ch.report_value, w.value);
            check_field("status",       rsp_ch.status,       w.status);
            check_field("output_drive", rsp_ch.output_drive, w.drive);
            check_field("led_on",       rsp_ch.led_on,       w.led);
            check_field("last",         rsp_ch.last,         w.last);
         end
      end
   end

   // run ceiling
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

// ===== gpio_change_monitor_pulse_out_core.f =====
+incdir+rtl
rtl/gcm_pkg.sv
rtl/gcm_req_if.sv
rtl/gcm_rsp_if.sv
rtl/gcm_lane.sv
rtl/gcm_timer.sv
rtl/gcm_merge.sv
rtl/gpio_change_monitor_pulse_out_core.sv
rtl/gcm_checker.sv
bench/gpio_change_monitor_pulse_out_core_test.sv
